FILE: rtl/cwdm_pkg.sv
// shared constants, types and sweep state codes for circular_window_distinct_max
// no dependencies
`default_nettype none

package cwdm_pkg;

    // ring capacity and size of the kind table (table size is a power of two)
    localparam int MaxItems   = 4096;
    localparam int KindCount  = 4096;

    // fixed widths of the interface fields
    localparam int InKindW    = 12;
    localparam int OutW       = 13;
    localparam int CfgLenW    = 13;
    localparam int CfgBonusW  = 12;

    // derived widths
    localparam int RingAw     = $clog2(MaxItems);
    localparam int KindW      = $clog2(KindCount);
    localparam int LenW       = $clog2(MaxItems + 1);
    localparam int CntW       = $clog2(MaxItems + 2);

    // queue between front and back
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    // apb register map
    localparam int PaddrW     = 3;
    localparam logic RegWindowLen = 1'b0;
    localparam logic RegBonusKind = 1'b1;

    // one ring item after folding
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic             last;
    } item_t;

    // handoff from front to queue
    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_LOAD,
        ST_SETUP,
        ST_BONUS_RC,
        ST_BONUS_WR,
        ST_FILL_RA,
        ST_FILL_RC,
        ST_FILL_WR,
        ST_SLOUT_RA,
        ST_SLOUT_RC,
        ST_SLOUT_WR,
        ST_SLIN_RA,
        ST_SLIN_RC,
        ST_SLIN_WR,
        ST_CLR_BONUS,
        ST_CLR_RA,
        ST_CLR_WR,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/cwdm_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module cwdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cwdm_front.sv
// front stage: takes input words, folds the kind into the table range, hands to queue
// depends on cwdm_pkg
`default_nettype none

module cwdm_front import cwdm_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [InKindW-1:0] kind,
    input  wire logic               last,
    input  wire logic               q_full,
    output push_t                   push
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    logic  take;
    logic  move;

    // word moves on to the queue whenever it has room
    assign move     = hold_valid_reg && !q_full;
    assign in_ready = !hold_valid_reg || !q_full;
    assign take     = in_valid && in_ready;

    assign push.valid = move;
    assign push.item  = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (move)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // holding register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // payload: kind reduced modulo the table size
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg.kind <= KindW'(kind);
            hold_item_reg.last <= last;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cwdm_queue.sv
// short fifo of ring items between the front stage and the sweep engine
// depends on cwdm_pkg
`default_nettype none

module cwdm_queue import cwdm_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  push_t      push,
    output logic       full,
    output logic       q_valid,
    output item_t      q_item,
    input  wire logic  pop
);

    item_t            slot [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QPtrW:0]   fill_reg;
    logic [QPtrW:0]   fill_next;
    logic             do_pop;

    assign full    = (fill_reg == (QPtrW+1)'(QueueDepth));
    assign q_valid = (fill_reg != '0);
    assign q_item  = slot[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (push.valid && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot[wr_ptr_reg] <= push.item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cwdm_back.sv
// sweep engine: stores the ring, slides the window over the count table, emits the best count
// depends on cwdm_pkg and cwdm_ram
`default_nettype none

module cwdm_back import cwdm_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  item_t                     q_item,
    output logic                      q_pop,
    input  wire logic [CfgLenW-1:0]   window_len,
    input  wire logic [CfgBonusW-1:0] bonus_kind,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [OutW-1:0]      best_distinct
);

    back_state_t       state_reg;
    back_state_t       state_next;

    logic [KindW-1:0]  clr_reg;
    logic [KindW-1:0]  clr_next;
    logic [LenW-1:0]   len_reg;
    logic [LenW-1:0]   len_next;
    logic [LenW-1:0]   win_reg;
    logic [LenW-1:0]   win_next;
    logic [LenW-1:0]   idx_reg;
    logic [LenW-1:0]   idx_next;
    logic [RingAw-1:0] tail_reg;
    logic [RingAw-1:0] tail_next;
    logic [RingAw-1:0] head_reg;
    logic [RingAw-1:0] head_next;
    logic [KindW-1:0]  kind_reg;
    logic [KindW-1:0]  kind_next;
    logic [KindW-1:0]  bonus_reg;
    logic [KindW-1:0]  bonus_next;
    logic [CntW-1:0]   distinct_reg;
    logic [CntW-1:0]   distinct_next;
    logic [CntW-1:0]   best_reg;
    logic [CntW-1:0]   best_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OutW-1:0]   out_data_reg;
    logic [OutW-1:0]   out_data_next;

    logic              ring_we;
    logic [RingAw-1:0] ring_waddr;
    logic [KindW-1:0]  ring_wdata;
    logic              ring_re;
    logic [RingAw-1:0] ring_raddr;
    logic [KindW-1:0]  ring_rdata;

    logic              cnt_we;
    logic [KindW-1:0]  cnt_waddr;
    logic [CntW-1:0]   cnt_wdata;
    logic              cnt_re;
    logic [KindW-1:0]  cnt_raddr;
    logic [CntW-1:0]   cnt_rdata;

    logic [CntW-1:0]   cnt_inc;
    logic [CntW-1:0]   cnt_dec;
    logic [CntW-1:0]   dist_inc;
    logic [CntW-1:0]   dist_dec;
    logic [LenW-1:0]   idx_inc;
    logic [LenW-1:0]   win_sel;
    logic [RingAw-1:0] tail_adv;
    logic [RingAw-1:0] head_adv;

    // ring of loaded kinds
    cwdm_ram #(
        .WIDTH (KindW),
        .DEPTH (MaxItems)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // per-kind occurrence counts
    cwdm_ram #(
        .WIDTH (CntW),
        .DEPTH (KindCount)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // count update arithmetic
    assign cnt_inc  = cnt_rdata + 1'b1;
    assign cnt_dec  = cnt_rdata - 1'b1;
    assign dist_inc = (cnt_rdata == '0) ? distinct_reg + 1'b1 : distinct_reg;
    assign dist_dec = (cnt_rdata == CntW'(1)) ? distinct_reg - 1'b1 : distinct_reg;
    assign idx_inc  = idx_reg + 1'b1;

    // ring pointers wrap at the ring length
    assign tail_adv = ((LenW'(tail_reg) + 1'b1) == len_reg) ? '0 : tail_reg + 1'b1;
    assign head_adv = ((LenW'(head_reg) + 1'b1) == len_reg) ? '0 : head_reg + 1'b1;

    // window length: zero means one, clamped to the ring length
    always_comb
    begin
        win_sel = (window_len == '0) ? LenW'(1) : LenW'(window_len);
        if (win_sel > len_reg)
        begin
            win_sel = len_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign best_distinct = out_data_reg;

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        len_next       = len_reg;
        win_next       = win_reg;
        idx_next       = idx_reg;
        tail_next      = tail_reg;
        head_next      = head_reg;
        kind_next      = kind_reg;
        bonus_next     = bonus_reg;
        distinct_next  = distinct_reg;
        best_next      = best_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        q_pop      = 1'b0;
        ring_we    = 1'b0;
        ring_waddr = len_reg[RingAw-1:0];
        ring_wdata = q_item.kind;
        ring_re    = 1'b0;
        ring_raddr = idx_reg[RingAw-1:0];
        cnt_we     = 1'b0;
        cnt_waddr  = kind_reg;
        cnt_wdata  = cnt_inc;
        cnt_re     = 1'b0;
        cnt_raddr  = ring_rdata;

        unique case (state_reg)
            // clearing pass over the count table after reset
            ST_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == KindW'(KindCount - 1))
                begin
                    state_next = ST_LOAD;
                end
            end

            // store ring items, drop those past capacity
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (len_reg != LenW'(MaxItems))
                    begin
                        ring_we  = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    if (q_item.last)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                win_next      = win_sel;
                bonus_next    = KindW'(bonus_kind);
                distinct_next = '0;
                idx_next      = '0;
                state_next    = ST_BONUS_RC;
            end

            // bonus kind enters the window
            ST_BONUS_RC:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = bonus_reg;
                kind_next  = bonus_reg;
                state_next = ST_BONUS_WR;
            end

            ST_BONUS_WR:
            begin
                cnt_we        = 1'b1;
                distinct_next = dist_inc;
                state_next    = ST_FILL_RA;
            end

            // first window position
            ST_FILL_RA:
            begin
                ring_re    = 1'b1;
                state_next = ST_FILL_RC;
            end

            ST_FILL_RC:
            begin
                cnt_re     = 1'b1;
                kind_next  = ring_rdata;
                state_next = ST_FILL_WR;
            end

            ST_FILL_WR:
            begin
                cnt_we        = 1'b1;
                distinct_next = dist_inc;
                if (idx_inc == win_reg)
                begin
                    best_next  = dist_inc;
                    idx_next   = '0;
                    tail_next  = '0;
                    head_next  = (win_reg == len_reg) ? '0 : win_reg[RingAw-1:0];
                    state_next = ST_SLOUT_RA;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_FILL_RA;
                end
            end

            // slide: tail item leaves
            ST_SLOUT_RA:
            begin
                ring_re    = 1'b1;
                ring_raddr = tail_reg;
                state_next = ST_SLOUT_RC;
            end

            ST_SLOUT_RC:
            begin
                cnt_re     = 1'b1;
                kind_next  = ring_rdata;
                state_next = ST_SLOUT_WR;
            end

            ST_SLOUT_WR:
            begin
                if (cnt_rdata != '0)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_dec;
                end
                distinct_next = dist_dec;
                state_next    = ST_SLIN_RA;
            end

            // slide: head item enters
            ST_SLIN_RA:
            begin
                ring_re    = 1'b1;
                ring_raddr = head_reg;
                state_next = ST_SLIN_RC;
            end

            ST_SLIN_RC:
            begin
                cnt_re     = 1'b1;
                kind_next  = ring_rdata;
                state_next = ST_SLIN_WR;
            end

            ST_SLIN_WR:
            begin
                cnt_we        = 1'b1;
                distinct_next = dist_inc;
                if (dist_inc > best_reg)
                begin
                    best_next = dist_inc;
                end
                tail_next = tail_adv;
                head_next = head_adv;
                if (idx_inc == len_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_CLR_BONUS;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SLOUT_RA;
                end
            end

            // the final window is the first one again: zero its kinds and the bonus
            ST_CLR_BONUS:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = bonus_reg;
                cnt_wdata  = '0;
                state_next = ST_CLR_RA;
            end

            ST_CLR_RA:
            begin
                ring_re    = 1'b1;
                state_next = ST_CLR_WR;
            end

            ST_CLR_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = ring_rdata;
                cnt_wdata = '0;
                if (idx_inc == win_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_CLR_RA;
                end
            end

            // hand the result to the output register
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OutW'(best_reg);
                    len_next       = '0;
                    distinct_next  = '0;
                    best_next      = '0;
                    state_next     = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            len_reg       <= '0;
            distinct_reg  <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            len_reg       <= len_next;
            distinct_reg  <= distinct_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sweep payload registers
    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        idx_reg      <= idx_next;
        tail_reg     <= tail_next;
        head_reg     <= head_next;
        kind_reg     <= kind_next;
        bonus_reg    <= bonus_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/circular_window_distinct_max_top.sv
// Block usage:
//   Input channel (in_valid/in_ready, kind, last) loads a ring of kinds, one word
//   per item; the word with last set closes the ring and starts the sweep.
//   Output channel (out_valid/out_ready, best_distinct) returns one word per ring:
//   the largest number of distinct kinds over all window positions, with the
//   bonus kind always counted. APB port: window_len at 0x0, bonus_kind at 0x4.
//   After the last item the sweep runs the window over the ring: every item's
//   count update is a ring read, a count-table read and a count-table write,
//   serialized on the single read port of each ram. Items of the next ring
//   queue up during the sweep until the four-entry queue and the input
//   register are full. Reset sets the config registers to 1 and runs a
//   clearing pass over all 4096 count-table entries, during which items only
//   fill the queue. When the receiver stalls, the result waits in the output
//   register and the sweep engine holds the next result until it is taken.
// depends on cwdm_pkg, cwdm_front, cwdm_queue, cwdm_back
`default_nettype none

module circular_window_distinct_max_top import cwdm_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [InKindW-1:0] kind,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [OutW-1:0]    best_distinct,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PaddrW-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    logic [CfgLenW-1:0]   window_len_reg;
    logic [CfgBonusW-1:0] bonus_kind_reg;
    logic                 cfg_wr;
    push_t                push;
    logic                 q_full;
    logic                 q_valid;
    item_t                q_item;
    logic                 q_pop;

    // apb register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= CfgLenW'(1);
            bonus_kind_reg <= CfgBonusW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                RegWindowLen: window_len_reg <= pwdata[CfgLenW-1:0];
                RegBonusKind: bonus_kind_reg <= pwdata[CfgBonusW-1:0];
                default:      window_len_reg <= window_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            RegWindowLen: prdata = 32'(window_len_reg);
            RegBonusKind: prdata = 32'(bonus_kind_reg);
            default:      prdata = '0;
        endcase
    end

    // input word register
    cwdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .last     (last),
        .q_full   (q_full),
        .push     (push)
    );

    // decoupling queue
    cwdm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (q_pop)
    );

    // ring store and window sweep
    cwdm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .window_len    (window_len_reg),
        .bonus_kind    (bonus_kind_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .best_distinct (best_distinct)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for circular_window_distinct_max_top: loads rings of kinds, checks each
// best distinct count against a model of the window sweep held in a scoreboard class
// depends on cwdm_pkg and the rtl of circular_window_distinct_max_top
`timescale 1ns / 1ps

module tb import cwdm_pkg::*; ();

    localparam int ItemTarget   = 1600;
    localparam int QuietItems   = 300;
    localparam int SettleCycles = 40;
    localparam int FullRingLen  = MaxItems + 4;

    // expected best distinct counts, worked out from every accepted word
    class distinct_scoreboard;
        logic [CfgLenW-1:0]   window_len;
        logic [CfgBonusW-1:0] bonus_kind;
        logic [InKindW-1:0]   ring_kinds [$];
        logic [OutW-1:0]      expected_best [$];
        int unsigned          kind_counts [KindCount];
        int unsigned          distinct_now;
        int unsigned          errors;

        function new();
            window_len = CfgLenW'(1);
            bonus_kind = CfgBonusW'(1);
            errors     = 0;
        endfunction

        function int pending();
            return expected_best.size();
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == RegWindowLen)
                window_len = data[CfgLenW-1:0];
            else
                bonus_kind = data[CfgBonusW-1:0];
        endfunction

        function void check_reg(logic idx, logic [31:0] got);
            logic [31:0] want;
            want = (idx == RegWindowLen) ? 32'(window_len) : 32'(bonus_kind);
            if (got !== want)
            begin
                $error("prdata mismatch at register %0d: expected %0d, actual %0d",
                       idx, want, got);
                errors++;
            end
        endfunction

        function void add_kind(logic [KindW-1:0] k);
            kind_counts[k]++;
            if (kind_counts[k] == 1)
                distinct_now++;
        endfunction

        function void drop_kind(logic [KindW-1:0] k);
            if (kind_counts[k] != 0)
            begin
                kind_counts[k]--;
                if (kind_counts[k] == 0)
                    distinct_now--;
            end
        endfunction

        // slide the clamped window once around the ring, bonus kind always in
        function logic [OutW-1:0] max_window_distinct();
            int unsigned n;
            int unsigned w;
            int unsigned head;
            int unsigned tail;
            int unsigned best;
            n = ring_kinds.size();
            w = window_len;
            if (w == 0)
                w = 1;
            if (w > n)
                w = n;
            foreach (kind_counts[i])
                kind_counts[i] = 0;
            distinct_now = 0;
            add_kind(bonus_kind);
            for (int i = 0; i < w; i++)
                add_kind(ring_kinds[i]);
            best = distinct_now;
            head = w % n;
            tail = 0;
            repeat (n)
            begin
                drop_kind(ring_kinds[tail]);
                add_kind(ring_kinds[head]);
                tail = (tail + 1) % n;
                head = (head + 1) % n;
                if (distinct_now > best)
                    best = distinct_now;
            end
            return best[OutW-1:0];
        endfunction

        // ring fills up to capacity; the word with last closes it
        function void note_kind(logic [InKindW-1:0] k, logic is_last);
            if (ring_kinds.size() < MaxItems)
                ring_kinds.push_back(k);
            if (is_last)
            begin
                expected_best.push_back(max_window_distinct());
                ring_kinds.delete();
            end
        endfunction

        function void check_best(logic [OutW-1:0] got);
            logic [OutW-1:0] want;
            if (expected_best.size() == 0)
            begin
                $error("best_distinct: unexpected word, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_best.pop_front();
                if (got !== want)
                begin
                    $error("best_distinct mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [InKindW-1:0]   kind;
    logic                 last;
    logic                 out_valid;
    logic                 out_ready;
    logic [OutW-1:0]      best_distinct;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PaddrW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    distinct_scoreboard   sb = new();
    int                   gap_pct;
    int                   stall_pct;
    bit                   quiet;
    int                   random_items;

    circular_window_distinct_max_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .best_distinct (best_distinct),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("[circular_window_distinct_max_top] ERROR");
        $finish;
    end

    // handshake monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_best(best_distinct);
            if (in_valid && in_ready)
                sb.note_kind(kind, last);
        end
    end

    // receiver with random stall bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    function automatic int idle_gap();
        if (quiet || $urandom_range(0, 99) >= gap_pct)
            return 0;
        return $urandom_range(1, 13);
    endfunction

    // offer one word, hold it until accepted
    task automatic send_word(input logic [InKindW-1:0] k, input logic is_last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = k;
        last     = is_last;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_seq(input logic [InKindW-1:0] seq [$]);
        foreach (seq[i])
            send_word(seq[i], i == seq.size() - 1);
    endtask

    // sender pauses until every result is back
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        drain();
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [PaddrW-1:0] addr, output logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // write a register, sometimes with junk above its width, then read it back
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [PaddrW-1:0] addr;
        logic [31:0]       data;
        logic [31:0]       junk;
        logic [31:0]       rd;
        int                width;
        addr  = {idx, 2'b00};
        width = (idx == RegWindowLen) ? CfgLenW : CfgBonusW;
        junk  = $urandom;
        data  = value;
        if ($urandom_range(0, 1))
            data = value | (junk & ~((32'd1 << width) - 1));
        apb_write(addr, data);
        sb.write_reg(idx, data);
        apb_read(addr, rd);
        sb.check_reg(idx, rd);
    endtask

    task automatic set_registers(input logic [CfgLenW-1:0] w, input logic [CfgBonusW-1:0] b);
        wait_idle();
        write_register(RegWindowLen, 32'(w));
        write_register(RegBonusKind, 32'(b));
    endtask

    // random ring: kinds from the full range or from a narrow band
    task automatic send_ring(input int n);
        int                 band;
        logic [InKindW-1:0] base;
        logic [InKindW-1:0] k;
        case ($urandom_range(0, 3))
            0: band = 0;
            1: band = $urandom_range(1, 4);
            2: band = $urandom_range(5, 32);
            default: band = $urandom_range(1, 12);
        endcase
        base = $urandom_range(0, 1) ? sb.bonus_kind : InKindW'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (band == 0)
                k = InKindW'($urandom_range(0, 4095));
            else
                k = base + InKindW'($urandom_range(0, band - 1));
            send_word(k, i == n - 1);
        end
        random_items += n;
    endtask

    function automatic logic [CfgLenW-1:0] pick_window();
        case ($urandom_range(0, 6))
            0: return CfgLenW'(0);
            1: return CfgLenW'(1);
            2: return CfgLenW'($urandom_range(2, 8));
            3: return CfgLenW'($urandom_range(9, 40));
            4: return CfgLenW'(4096);
            5: return CfgLenW'(8191);
            default: return CfgLenW'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    // main sequence
    initial
    begin
        logic [InKindW-1:0] seq [$];
        logic [InKindW-1:0] k;
        logic [CfgBonusW-1:0] b;
        int rings;
        int n;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = '0;
        last         = 1'b0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        gap_pct      = 20;
        stall_pct    = 20;
        quiet        = 1'b0;
        random_items = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes under reset registers, single-word ring
        seq = '{12'd0, 12'd4095};
        send_seq(seq);
        seq = '{12'd1};
        send_seq(seq);

        // zero window, bonus kind zero
        set_registers(13'd0, 12'd0);
        seq = '{12'd0, 12'd0, 12'd7, 12'd4095};
        send_seq(seq);

        // window far longer than the ring, top bonus kind
        set_registers(13'd8191, 12'd4095);
        seq = '{12'd4095, 12'd1, 12'd2, 12'd3, 12'd4095};
        send_seq(seq);

        // clamp at the largest legal window, ring of one repeated kind
        set_registers(13'd4096, 12'd2048);
        seq = '{12'd2048, 12'd2048, 12'd2048};
        send_seq(seq);

        // short window sliding over a ring that wraps
        set_registers(13'd3, 12'd100);
        seq = '{12'd1, 12'd2, 12'd3, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5};
        send_seq(seq);

        // full ring of every kind, extra words dropped, last on a dropped word
        b = CfgBonusW'($urandom_range(0, 4095));
        set_registers(13'd4096, b);
        gap_pct   = 5;
        stall_pct = 10;
        for (int i = 0; i < FullRingLen; i++)
        begin
            k = (i < MaxItems) ? (InKindW'(i) ^ 12'hA5C) : InKindW'($urandom);
            send_word(k, i == FullRingLen - 1);
        end

        // random phases, each under its own register setting
        while (random_items < ItemTarget)
        begin
            if (random_items >= ItemTarget - QuietItems)
                quiet = 1'b1;
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            set_registers(pick_window(),
                          $urandom_range(0, 3) == 0 ? 12'd0 :
                          $urandom_range(0, 2) == 0 ? 12'd4095 : 12'($urandom));
            rings = $urandom_range(3, 10);
            repeat (rings)
            begin
                if ($urandom_range(0, 39) == 0)
                    n = $urandom_range(25, 300);
                else
                    n = $urandom_range(1, 24);
                send_ring(n);
                if ($urandom_range(0, 7) == 0)
                    drain();
            end
        end

        // wind down
        quiet = 1'b1;
        drain();
        repeat (SettleCycles) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[circular_window_distinct_max_top] OK");
        else
            $display("[circular_window_distinct_max_top] ERROR");
        $finish;
    end

endmodule
